FILE: rtl/bsal_pkg.sv
package bsal_pkg;

  localparam int CAPACITY_DEF     = 128;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam int OP_W    = 3;
  localparam int KEY_W   = 31;
  localparam int PAY_W   = 32;
  localparam int POS_W   = 8;
  localparam int COUNT_W = 8;

  localparam logic [OP_W-1:0] OP_INS_TAIL   = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_HEAD   = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_SORTED = 3'd2;
  localparam logic [OP_W-1:0] OP_RM_TAIL    = 3'd3;
  localparam logic [OP_W-1:0] OP_RM_HEAD    = 3'd4;
  localparam logic [OP_W-1:0] OP_RM_KEY     = 3'd5;
  localparam logic [OP_W-1:0] OP_READ_POS   = 3'd6;
  localparam logic [OP_W-1:0] OP_FIND_KEY   = 3'd7;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture the incoming transaction
    logic exec;   // apply the update and load the result register
  } bsal_cmd_t;

endpackage

FILE: rtl/bounded_sorted_array_list_core.sv
// Bounded sorted array list: up to CAPACITY entries of (31-bit key, payload)
// kept in a row of shift-register cells. Each input transaction carries one
// opcode (insert tail/head/sorted, remove tail/head/key, read by 1-based
// position, find key) and yields exactly one result transaction with ok,
// the key and payload read (zero unless a read succeeded) and the entry
// count after the operation. Each transaction goes through an evaluate step,
// in which every cell compares its key against the request in parallel
// and registers the result, then an execute step, in which the first-hit
// priority pick drives the shift/write of all cells and loads the result
// register. A new transaction is taken at the earliest in the cycle its
// predecessor completes, so a held result does not block input until the
// next result needs the register.
// Entry contents are undefined until written; the count resets to zero.
module bounded_sorted_array_list_core #(
  parameter int CAPACITY     = bsal_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_BITS = bsal_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bsal_pkg::OP_W-1:0]    in_opcode,
  input  logic [bsal_pkg::KEY_W-1:0]   in_entry_key,
  input  logic [bsal_pkg::PAY_W-1:0]   in_entry_payload,
  input  logic [bsal_pkg::POS_W-1:0]   in_position,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_ok,
  output logic [bsal_pkg::KEY_W-1:0]   out_key,
  output logic [bsal_pkg::PAY_W-1:0]   out_payload,
  output logic [bsal_pkg::COUNT_W-1:0] out_count
);

  bsal_pkg::bsal_cmd_t cmd;

  // sequencing and output handshake
  bsal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // entry cells, compares, result register
  bsal_dp #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_opcode        (in_opcode),
    .in_entry_key     (in_entry_key),
    .in_entry_payload (in_entry_payload),
    .in_position      (in_position),
    .out_ok           (out_ok),
    .out_key          (out_key),
    .out_payload      (out_payload),
    .out_count        (out_count)
  );

endmodule

FILE: rtl/bsal_ctrl.sv
module bsal_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output bsal_pkg::bsal_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) || ((state_r == S_EXEC) && out_free);
  assign cmd.load  = in_valid && in_ready;
  assign cmd.exec  = (state_r == S_EXEC) && out_free;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (cmd.load) state_nxt = S_EVAL;
      S_EVAL: state_nxt = S_EXEC;
      S_EXEC: if (cmd.exec) state_nxt = cmd.load ? S_EVAL : S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.exec) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/bsal_dp.sv
module bsal_dp #(
  parameter int CAPACITY     = bsal_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_BITS = bsal_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bsal_pkg::bsal_cmd_t          cmd,
  input  logic [bsal_pkg::OP_W-1:0]    in_opcode,
  input  logic [bsal_pkg::KEY_W-1:0]   in_entry_key,
  input  logic [bsal_pkg::PAY_W-1:0]   in_entry_payload,
  input  logic [bsal_pkg::POS_W-1:0]   in_position,
  output logic                         out_ok,
  output logic [bsal_pkg::KEY_W-1:0]   out_key,
  output logic [bsal_pkg::PAY_W-1:0]   out_payload,
  output logic [bsal_pkg::COUNT_W-1:0] out_count
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int KW = bsal_pkg::KEY_W;
  localparam logic [CAPACITY-1:0] ONE = {{(CAPACITY-1){1'b0}}, 1'b1};

  // latched transaction
  logic [bsal_pkg::OP_W-1:0]  op_r;
  logic [KW-1:0]              key_r;
  logic [PAYLOAD_BITS-1:0]    pay_r;
  logic [bsal_pkg::POS_W-1:0] pos_r;

  // entry cells
  logic [KW-1:0]           key_q   [CAPACITY];
  logic [PAYLOAD_BITS-1:0] pay_q   [CAPACITY];
  logic [CW-1:0]           count_r, count_nxt;

  // per-cell compare results, registered
  logic [CAPACITY-1:0] eq_r, lt_r;

  logic [CAPACITY-1:0] valid, tail_oh, pos_oh;
  logic [CAPACITY-1:0] match, match_first, sorted_f, sorted_first;
  logic [CAPACITY-1:0] ins_first, ins_ge, rm_first, rm_ge, rd_sel;
  logic                full, empty, found, pos_ok;
  logic                ins_do, rm_shift, rm_do, rd_ok;
  logic [KW-1:0]           rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_opcode;
      key_r <= in_entry_key;
      pay_r <= PAYLOAD_BITS'(in_entry_payload);
      pos_r <= in_position;
    end
  end

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cmp
    assign valid[j]   = 32'(j) < 32'(count_r);
    assign tail_oh[j] = 32'(j) == 32'(count_r);
    assign pos_oh[j]  = 32'(j + 1) == 32'(pos_r);
    always_ff @(posedge clk) begin
      eq_r[j] <= key_q[j] == key_r;
      lt_r[j] <= key_q[j] < key_r;
    end
  end

  assign full  = 32'(count_r) == 32'(CAPACITY);
  assign empty = count_r == '0;

  // first matching entry and first entry not below the new key
  assign match        = eq_r & valid;
  assign match_first  = match & (~match + ONE);
  assign found        = |match;
  assign sorted_f     = ~lt_r | ~valid;
  assign sorted_first = sorted_f & (~sorted_f + ONE);
  assign pos_ok       = (pos_r != '0) && (32'(pos_r) <= 32'(count_r));

  always_comb begin
    ins_first = '0;
    rm_first  = '0;
    rd_sel    = '0;
    ins_do    = 1'b0;
    rm_shift  = 1'b0;
    rm_do     = 1'b0;
    rd_ok     = 1'b0;
    case (op_r)
      bsal_pkg::OP_INS_TAIL: begin
        ins_first = tail_oh;
        ins_do    = !full;
      end
      bsal_pkg::OP_INS_HEAD: begin
        ins_first = ONE;
        ins_do    = !full;
      end
      bsal_pkg::OP_INS_SORTED: begin
        ins_first = sorted_first;
        ins_do    = !full;
      end
      bsal_pkg::OP_RM_TAIL: rm_do = !empty;
      bsal_pkg::OP_RM_HEAD: begin
        rm_first = ONE;
        rm_do    = !empty;
        rm_shift = !empty;
      end
      bsal_pkg::OP_RM_KEY: begin
        rm_first = match_first;
        rm_do    = found;
        rm_shift = found;
      end
      bsal_pkg::OP_READ_POS: begin
        rd_sel = pos_oh;
        rd_ok  = pos_ok;
      end
      bsal_pkg::OP_FIND_KEY: begin
        rd_sel = match_first;
        rd_ok  = (key_r != '0) && found;
      end
      default: ;
    endcase
  end

  assign ins_ge = ~(ins_first - ONE);
  assign rm_ge  = ~(rm_first - ONE);

  always_comb begin
    rd_key = '0;
    rd_pay = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      rd_key = rd_key | (key_q[j] & {KW{rd_sel[j]}});
      rd_pay = rd_pay | (pay_q[j] & {PAYLOAD_BITS{rd_sel[j]}});
    end
  end

  // cells: insert shifts up from the slot, removal shifts down into it
  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.exec) begin
        if (ins_do && ins_ge[j]) begin
          if (ins_first[j]) begin
            key_q[j] <= key_r;
            pay_q[j] <= pay_r;
          end else begin
            if (j > 0) begin
              key_q[j] <= key_q[(j > 0) ? j - 1 : 0];
              pay_q[j] <= pay_q[(j > 0) ? j - 1 : 0];
            end
          end
        end else if (rm_shift && rm_ge[j] && (j < CAPACITY - 1)) begin
          key_q[j] <= key_q[(j < CAPACITY - 1) ? j + 1 : j];
          pay_q[j] <= pay_q[(j < CAPACITY - 1) ? j + 1 : j];
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ins_do) count_nxt = count_r + CW'(1);
    else if (rm_do) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_ok      <= ins_do || rm_do || rd_ok;
      out_key     <= rd_ok ? rd_key : '0;
      out_payload <= rd_ok ? bsal_pkg::PAY_W'(rd_pay) : '0;
      out_count   <= bsal_pkg::COUNT_W'(count_nxt);
    end
  end

endmodule
